### design/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define CSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is held.
`define CSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

### design/csp_pkg.sv
// Shared types, command codes and parameter defaults for the pattern search core.
`timescale 1ns / 1ps
package csp_pkg;

  localparam int MAX_PATTERN_DEF = 32;
  localparam int PART_WIDTH_DEF  = 32;
  localparam int COUNT_W         = 6;

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_PUSH   = 2'd2;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] element_real;
    logic signed [31:0] element_imag;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] pattern_count;
    logic               pattern_overflow;
  } out_item_t;

  // Broadcast strobes to every cell, one transaction at most.
  typedef struct packed {
    logic clear;
    logic append;
    logic push;
  } cell_ctrl_t;

endpackage

### design/csp_cell.sv
// One comparator cell: a stored pattern element, its occupancy bit and its partial-match bit.
`timescale 1ns / 1ps
module csp_cell #(
  parameter int PART_WIDTH = csp_pkg::PART_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  csp_pkg::cell_ctrl_t     ctrl,
  input  logic [2*PART_WIDTH-1:0] elem,
  input  logic                    prev_active,
  input  logic                    prev_match,
  input  logic                    next_active,
  output logic                    active,
  output logic                    match,
  output logic                    hit
);

  logic [2*PART_WIDTH-1:0] pat_r;
  logic                    active_r, active_nxt;
  logic                    match_r, match_nxt;
  logic                    wr_en;

  // first free cell: lower neighbor occupied, this one empty
  assign wr_en = ctrl.append && !active_r && prev_active;

  always_comb begin
    active_nxt = active_r;
    match_nxt  = match_r;
    if (ctrl.clear) begin
      active_nxt = 1'b0;
      match_nxt  = 1'b0;
    end else if (ctrl.append) begin
      if (wr_en) begin
        active_nxt = 1'b1;
        match_nxt  = 1'b0;
      end
    end else if (ctrl.push) begin
      match_nxt = active_r && prev_match && (pat_r == elem);
    end
  end

  // tail cell completing a full match
  assign hit = ctrl.push && match_nxt && active_r && !next_active;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      match_r  <= 1'b0;
    end else begin
      active_r <= active_nxt;
      match_r  <= match_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      pat_r <= elem;
    end
  end

  assign active = active_r;
  assign match  = match_r;

endmodule

### design/contiguous_pattern_search_core.sv
// Top level of the streaming contiguous pattern search: cell row, flags and result register.
//
//  channel | direction | ports                          | payload
//  --------+-----------+--------------------------------+---------------------
//  input   | in        | in_valid, in_ready, in_data    | csp_pkg::in_item_t
//  result  | out       | out_valid, out_ready, out_data | csp_pkg::out_item_t
//
// Every accepted transaction updates the state in the cycle it is taken and
// loads one result into the output register; the result appears in the next cycle.
// Sustained rate is one transaction per cycle while no result is stalled: all cells
// compare the pushed element in parallel and the match bit moves one cell up the row per push.
// in_ready is high while the output register is empty or being drained.
// Synchronous active-low reset empties the pattern, match bits and flags.
// A stalled result holds its value; no input is taken until it drains.
`timescale 1ns / 1ps
module contiguous_pattern_search_core #(
  parameter int MAX_PATTERN = csp_pkg::MAX_PATTERN_DEF,
  parameter int PART_WIDTH  = csp_pkg::PART_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  csp_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output csp_pkg::out_item_t  out_data
);

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);

  logic                    in_fire;
  csp_pkg::cell_ctrl_t     ctrl;
  logic [2*PART_WIDTH-1:0] elem;

  logic [MAX_PATTERN-1:0]  act_vec;
  logic [MAX_PATTERN-1:0]  match_vec;
  logic [MAX_PATTERN-1:0]  hit_vec;

  logic [CNT_W-1:0]        count_r, count_nxt;
  logic                    found_r, found_nxt;
  logic                    ovf_r, ovf_nxt;
  logic                    full;
  logic [CNT_W+csp_pkg::COUNT_W-1:0] count_ext;

  logic                    out_valid_r;
  csp_pkg::out_item_t      out_data_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // decode the command once; code 3 raises no strobe and leaves state alone
  always_comb begin
    ctrl = '0;
    if (in_fire) begin
      case (in_data.command)
        csp_pkg::CMD_CLEAR:  ctrl.clear  = 1'b1;
        csp_pkg::CMD_APPEND: ctrl.append = 1'b1;
        csp_pkg::CMD_PUSH:   ctrl.push   = 1'b1;
        default:             ctrl        = '0;
      endcase
    end
  end

  // only the low PART_WIDTH bits of each part take part in the compare
  assign elem = {in_data.element_imag[PART_WIDTH-1:0],
                 in_data.element_real[PART_WIDTH-1:0]};

  // cell row: cell 0 sees an always-true prefix, the top cell has no upper neighbor
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    logic prev_act, prev_mat, next_act;
    if (i == 0) begin : g_first
      assign prev_act = 1'b1;
      assign prev_mat = 1'b1;
    end else begin : g_link
      assign prev_act = act_vec[i-1];
      assign prev_mat = match_vec[i-1];
    end
    if (i == MAX_PATTERN - 1) begin : g_last
      assign next_act = 1'b0;
    end else begin : g_up
      assign next_act = act_vec[i+1];
    end

    csp_cell #(
      .PART_WIDTH (PART_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .elem        (elem),
      .prev_active (prev_act),
      .prev_match  (prev_mat),
      .next_active (next_act),
      .active      (act_vec[i]),
      .match       (match_vec[i]),
      .hit         (hit_vec[i])
    );
  end

  assign full = (count_r == CNT_W'(MAX_PATTERN));

  // length counter and sticky flags; hits come only from the tail cell
  always_comb begin
    count_nxt = count_r;
    found_nxt = found_r;
    ovf_nxt   = ovf_r;
    if (ctrl.clear) begin
      count_nxt = '0;
      found_nxt = 1'b0;
      ovf_nxt   = 1'b0;
    end else if (ctrl.append) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end else if (ctrl.push) begin
      found_nxt = found_r || (|hit_vec);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      found_r <= 1'b0;
      ovf_r   <= 1'b0;
    end else begin
      count_r <= count_nxt;
      found_r <= found_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // fit the internal count to the fixed result field
  assign count_ext = (CNT_W + csp_pkg::COUNT_W)'(count_nxt);

  // output register: loaded on every accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r.found            <= found_nxt;
      out_data_r.pattern_count    <= count_ext[csp_pkg::COUNT_W-1:0];
      out_data_r.pattern_overflow <= ovf_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### design/csp_checker.sv
// Port-level checker for the pattern search core, with its bind.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module csp_checker #(
  parameter int MAX_PATTERN = csp_pkg::MAX_PATTERN_DEF
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input csp_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input csp_pkg::out_item_t out_data
);

  logic out_stall;
  logic clear_fire;
  logic out_empty;
  logic count_zero;

  assign out_stall  = out_valid && !out_ready;
  assign clear_fire = in_valid && in_ready && (in_data.command == csp_pkg::CMD_CLEAR);
  assign count_zero = (out_data.pattern_count == '0);
  assign out_empty  = !out_data.found && count_zero && !out_data.pattern_overflow;

  // a stalled result holds
  `CSP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_data))

  // a clear transaction yields an all-empty result next cycle
  `CSP_ASSERT_NEXT(a_clear_result, clk, rst_n, clear_fire, out_valid && out_empty)

  // the count never passes the store depth
  `CSP_ASSERT_NOW(a_count_bound, clk, rst_n, out_valid, 32'(out_data.pattern_count) <= MAX_PATTERN)

  // an empty pattern cannot have matched
  `CSP_ASSERT_NOW(a_empty_no_found, clk, rst_n, out_valid && count_zero, !out_data.found)

endmodule

bind contiguous_pattern_search_core csp_checker #(
  .MAX_PATTERN (MAX_PATTERN)
) u_csp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### sim/contiguous_pattern_search_core_test.sv
// Self-checking testbench for the streaming contiguous pattern search core.
`timescale 1ns / 1ps
module contiguous_pattern_search_core_test;

  localparam int MAXP = csp_pkg::MAX_PATTERN_DEF;
  // Command code the block must ignore; the package names only the three real ones.
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 500;
  // No idling once this few transactions remain to be sent.
  localparam int CALM_TAIL = 60;
  localparam int HOLD_AFTER = 150;
  localparam int HOLD_CYCLES = 200;
  localparam int CYCLE_LIMIT = 200000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  csp_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  csp_pkg::out_item_t out_data;

  contiguous_pattern_search_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Transactions waiting to be offered, and the status words still owed by the block.
  csp_pkg::in_item_t send_q [$];
  csp_pkg::out_item_t status_q [$];

  int mismatches = 0;
  int items_taken = 0;
  int cycle_count = 0;
  logic in_taken = 1'b0;
  logic hold_off = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  // ---------------------------------------------------------------------------
  // Predictor state: stored pattern, one prefix-hit bit per pattern position,
  // and the two sticky flags.
  // ---------------------------------------------------------------------------
  bit [63:0] pat_mem [MAXP];
  int pat_len = 0;
  bit [MAXP-1:0] prefix_hit = '0;
  bit seen_match = 1'b0;
  bit store_full_hit = 1'b0;

  function automatic csp_pkg::out_item_t search_step(csp_pkg::in_item_t item);
    bit [63:0] elem;
    bit below;
    csp_pkg::out_item_t status;
    elem = {item.element_imag, item.element_real};
    case (item.command)
      csp_pkg::CMD_CLEAR: begin
        pat_len = 0;
        prefix_hit = '0;
        seen_match = 1'b0;
        store_full_hit = 1'b0;
      end
      csp_pkg::CMD_APPEND: begin
        if (pat_len < MAXP) begin
          pat_mem[pat_len] = elem;
          prefix_hit[pat_len] = 1'b0;
          pat_len++;
        end else begin
          store_full_hit = 1'b1;
        end
      end
      csp_pkg::CMD_PUSH: begin
        // Top down, so each position sees the previous value of the one below.
        for (int p = MAXP - 1; p >= 0; p--) begin
          below = (p == 0) ? 1'b1 : prefix_hit[p-1];
          prefix_hit[p] = (p < pat_len) && below && (pat_mem[p] == elem);
        end
        if (pat_len > 0 && prefix_hit[pat_len-1])
          seen_match = 1'b1;
      end
      default: ;
    endcase
    status.found = seen_match;
    status.pattern_count = csp_pkg::COUNT_W'(pat_len);
    status.pattern_overflow = store_full_hit;
    return status;
  endfunction

  function automatic csp_pkg::in_item_t make_item(logic [1:0] cmd, logic [63:0] elem);
    csp_pkg::in_item_t item;
    item.command = cmd;
    item.element_imag = elem[63:32];
    item.element_real = elem[31:0];
    return item;
  endfunction

  // One search round: clear, load a pattern, then stream text drawn from a small
  // alphabet so that partial matches are common, often with the pattern planted.
  task automatic queue_search_round();
    logic [63:0] alpha [4];
    logic [63:0] pat [$];
    logic [63:0] elem;
    int shape, plen, tlen, plant_at, late_tail;
    shape = $urandom_range(0, 19);
    for (int i = 0; i < 4; i++)
      alpha[i] = {$urandom, $urandom};
    alpha[3][63:32] = '0;  // plain value
    if (shape == 0)
      plen = $urandom_range(MAXP, MAXP + 4);  // fill the store, and overrun it unless plen is exactly MAXP
    else if (shape == 1)
      plen = 0;
    else
      plen = $urandom_range(1, 6);
    for (int i = 0; i < plen; i++)
      pat.push_back(alpha[$urandom_range(0, 3)]);
    tlen = plen + $urandom_range(2, 20);
    plant_at = ($urandom_range(0, 2) != 0) ? $urandom_range(0, tlen - plen) : -1;
    // Hold back the last pattern element until the text is mid-match.
    late_tail = (shape == 2 && plen >= 2 && plant_at >= 0) ? 1 : 0;

    send_q.push_back(make_item(csp_pkg::CMD_CLEAR, {$urandom, $urandom}));
    for (int i = 0; i < plen - late_tail; i++)
      send_q.push_back(make_item(csp_pkg::CMD_APPEND, pat[i]));
    for (int i = 0; i < tlen; i++) begin
      if (plant_at >= 0 && i >= plant_at && i < plant_at + plen)
        elem = pat[i-plant_at];
      else if ($urandom_range(0, 9) == 0)
        elem = {$urandom, $urandom};
      else
        elem = alpha[$urandom_range(0, 3)];
      send_q.push_back(make_item(csp_pkg::CMD_PUSH, elem));
      if (late_tail != 0 && i == plant_at + plen - 2)
        send_q.push_back(make_item(csp_pkg::CMD_APPEND, pat[plen-1]));
      if ($urandom_range(0, 24) == 0)
        send_q.push_back(make_item(CMD_UNUSED, {$urandom, $urandom}));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge, predict on every input
  // transaction and check every result transaction against the oldest status.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    csp_pkg::out_item_t want;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      status_q.push_back(search_step(in_data));
      items_taken <= items_taken + 1;
    end
    if (rst_n && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
        mismatches++;
      end else begin
        want = status_q.pop_front();
        if (out_data.found !== want.found) begin
          $display("%0t: found expected %0d, actual %0d", $time, want.found, out_data.found);
          mismatches++;
        end
        if (out_data.pattern_count !== want.pattern_count) begin
          $display("%0t: pattern_count expected %0d, actual %0d", $time,
                   want.pattern_count, out_data.pattern_count);
          mismatches++;
        end
        if (out_data.pattern_overflow !== want.pattern_overflow) begin
          $display("%0t: pattern_overflow expected %0d, actual %0d", $time,
                   want.pattern_overflow, out_data.pattern_overflow);
          mismatches++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: changes inputs at the falling edge. A held transaction stays put
  // until taken; otherwise the next one is loaded or a random gap is inserted.
  // Gaps only start in part of each repeating cycle-counter window, so quiet stretches remain.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (send_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (send_q.size() > CALM_TAIL && (cycle_count % 160) < 100 &&
                   $urandom_range(0, 7) == 0) begin
        gap_left = $urandom_range(0, 13);
        in_valid <= 1'b0;
      end else begin
        in_data <= send_q.pop_front();
        in_valid <= 1'b1;
      end
    end
  end

  // Receiver: random stall bursts in part of each repeating cycle-counter window, plus the
  // long hold-off below that backs the block up into in_ready.
  always @(negedge clk) begin
    if (!rst_n || hold_off) begin
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (send_q.size() > CALM_TAIL && (cycle_count % 112) < 64 &&
                 $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  initial begin
    wait (items_taken >= HOLD_AFTER);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("contiguous_pattern_search_core regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    logic [63:0] ea, eb, ec, ed, ee;
    int directed;
    ea = {32'h8000_0000, 32'h7FFF_FFFF};  // most negative imag, most positive real
    eb = {32'hFFFF_FFFF, 32'h8000_0000};
    ec = {32'h0000_0000, 32'h0000_0001};
    ed = {32'h7FFF_FFFF, 32'hFFFF_FFFF};
    ee = {32'h0000_0000, 32'h0000_0000};

    // Empty pattern: a text push never matches.
    send_q.push_back(make_item(csp_pkg::CMD_PUSH, ee));
    // Extreme values, two-element match, ignored command, clear.
    send_q.push_back(make_item(csp_pkg::CMD_CLEAR, '1));
    send_q.push_back(make_item(csp_pkg::CMD_APPEND, ea));
    send_q.push_back(make_item(csp_pkg::CMD_APPEND, eb));
    send_q.push_back(make_item(csp_pkg::CMD_PUSH, ea));
    send_q.push_back(make_item(csp_pkg::CMD_PUSH, eb));
    send_q.push_back(make_item(CMD_UNUSED, '1));
    send_q.push_back(make_item(csp_pkg::CMD_CLEAR, ee));
    // Text shorter than the pattern, then the pattern grown mid-stream.
    send_q.push_back(make_item(csp_pkg::CMD_APPEND, ec));
    send_q.push_back(make_item(csp_pkg::CMD_APPEND, ed));
    send_q.push_back(make_item(csp_pkg::CMD_PUSH, ec));
    send_q.push_back(make_item(csp_pkg::CMD_APPEND, ee));
    send_q.push_back(make_item(csp_pkg::CMD_PUSH, ed));
    send_q.push_back(make_item(csp_pkg::CMD_PUSH, ee));
    // Found stays set across later appends and text.
    send_q.push_back(make_item(csp_pkg::CMD_APPEND, ea));
    send_q.push_back(make_item(csp_pkg::CMD_PUSH, eb));
    // Same real part, different imaginary part must not match.
    send_q.push_back(make_item(csp_pkg::CMD_CLEAR, ee));
    send_q.push_back(make_item(csp_pkg::CMD_APPEND, {32'd0, 32'd5}));
    send_q.push_back(make_item(csp_pkg::CMD_PUSH, {32'd7, 32'd5}));
    send_q.push_back(make_item(csp_pkg::CMD_PUSH, {32'd0, 32'd5}));
    directed = send_q.size();

    while (send_q.size() < directed + RANDOM_ITEMS)
      queue_search_round();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    wait (send_q.size() == 0 && !in_valid);
    wait (status_q.size() == 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("contiguous_pattern_search_core regression: pass");
    else
      $display("contiguous_pattern_search_core regression: fail");
    $finish;
  end

endmodule
